// File: hdl/tces_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tces_pkg: shared types and constants for the tone channel control block
// Request codes, register indexes, field widths and the state and
// configuration records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package tces_pkg;

   localparam int GAIN_W  = 17;
   localparam int SWEEP_W = 18;
   localparam int WORD_W  = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN  = 17'h10000;
   localparam logic [SWEEP_W-1:0] UNITY_SWEEP = 18'h10000;

   // request codes carried by req_type
   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_PLAY = 2'd1,
      REQ_STOP = 2'd2
   } req_kind_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_START   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_END     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_MS    = 3'd5;

   typedef struct packed {
      logic [GAIN_W-1:0]  start_gain;
      logic [GAIN_W-1:0]  decay_factor;
      logic [SWEEP_W-1:0] sweep_factor;
      logic [WORD_W-1:0]  freq_start;
      logic [WORD_W-1:0]  freq_end;
      logic [WORD_W-1:0]  length_ms;
   } chan_cfg_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_now;
      logic [WORD_W-1:0] freq_now;
      logic [WORD_W-1:0] start_time;
      logic              sounding;
   } chan_state_type;

endpackage : tces_pkg
`default_nettype wire

// File: hdl/tone_channel_envelope_sweep_unit.sv
`default_nettype none
// An accepted word waits in the stage register until the result register is free or being emptied.
// Throughput: one word per cycle unless responses stall; state updates with the result register.
// The stage and result registers pass ready through, so a stalled response holds the stage.
// Reset: synchronous, active high; clears state, sets start_gain to unity, others to zero.
// Configuration writes take effect at once and are always accepted.
// ----------------------------------------------------------------------------
// tone_channel_envelope_sweep_unit: control block of one sound channel
// Note length, gain decay and frequency sweep, updated on tick words,
// restarted on play words and ended on stop words.
// ----------------------------------------------------------------------------
module tone_channel_envelope_sweep_unit (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [1:0]                         req_type,
   input  wire [tces_pkg::WORD_W-1:0]        req_now_ms,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [tces_pkg::GAIN_W-1:0]       rsp_gain_out,
   output logic [tces_pkg::WORD_W-1:0]       rsp_freq_out,
   output logic                              rsp_playing,
   output logic                              rsp_stop_event,
   // register write channel
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [tces_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [tces_pkg::WORD_W-1:0]        csr_data
);

   tces_pkg::chan_cfg_type   cfg_ff;
   tces_pkg::chan_state_type state_ff;
   tces_pkg::chan_state_type state_in;

   logic                          s1_valid_ff;
   logic [1:0]                    s1_type_ff;
   logic [tces_pkg::WORD_W-1:0]   s1_now_ff;
   logic                          advance;
   logic                          step_stop;

   logic                          rsp_valid_ff;
   logic [tces_pkg::GAIN_W-1:0]   rsp_gain_ff;
   logic [tces_pkg::WORD_W-1:0]   rsp_freq_ff;
   logic                          rsp_playing_ff;
   logic                          rsp_stop_ff;

   assign csr_ready = 1'b1;

   // write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_gain   <= tces_pkg::UNITY_GAIN;
         cfg_ff.decay_factor <= '0;
         cfg_ff.sweep_factor <= '0;
         cfg_ff.freq_start   <= '0;
         cfg_ff.freq_end     <= '0;
         cfg_ff.length_ms    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tces_pkg::CSR_START_GAIN:   cfg_ff.start_gain   <= csr_data[tces_pkg::GAIN_W-1:0];
            tces_pkg::CSR_DECAY_FACTOR: cfg_ff.decay_factor <= csr_data[tces_pkg::GAIN_W-1:0];
            tces_pkg::CSR_SWEEP_FACTOR: cfg_ff.sweep_factor <= csr_data[tces_pkg::SWEEP_W-1:0];
            tces_pkg::CSR_FREQ_START:   cfg_ff.freq_start   <= csr_data;
            tces_pkg::CSR_FREQ_END:     cfg_ff.freq_end     <= csr_data;
            tces_pkg::CSR_LENGTH_MS:    cfg_ff.length_ms    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // advance the stage when the result register is free or being emptied
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // hold the accepted request word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_type_ff <= req_type;
         s1_now_ff  <= req_now_ms;
      end
   end

   tces_step u_step (
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .kind       (s1_type_ff),
      .now_ms     (s1_now_ff),
      .nxt        (state_in),
      .stop_event (step_stop)
   );

   // update channel state as the word moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_gain_ff    <= state_in.gain_now;
         rsp_freq_ff    <= state_in.freq_now;
         rsp_playing_ff <= state_in.sounding;
         rsp_stop_ff    <= step_stop;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gain_out   = rsp_gain_ff;
   assign rsp_freq_out   = rsp_freq_ff;
   assign rsp_playing    = rsp_playing_ff;
   assign rsp_stop_event = rsp_stop_ff;

`ifndef NO_ASSERTIONS
   // gain never rises above unity
   a_gain_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gain_ff <= tces_pkg::UNITY_GAIN))
      else $error("gain above unity");

   // a stop event always leaves the note silent
   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stop_ff) |-> !rsp_playing_ff)
      else $error("stop event while still playing");

   // a play word yields a sounding response
   a_play_sounds: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_type_ff == tces_pkg::REQ_PLAY)) |=> (rsp_valid_ff && rsp_playing_ff))
      else $error("play did not start the note");

   // an empty stage always takes a word
   a_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("empty stage refused a word");
`endif

endmodule : tone_channel_envelope_sweep_unit
`default_nettype wire

// File: hdl/tces_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tces_step: next-state logic for one request word
// Applies play, stop or tick to the channel state (other codes leave it): note length check,
// gain decay product and saturating frequency sweep with end stop.
// ----------------------------------------------------------------------------
module tces_step (
   input  wire tces_pkg::chan_cfg_type   cfg,
   input  wire tces_pkg::chan_state_type cur,
   input  wire [1:0]                     kind,
   input  wire [tces_pkg::WORD_W-1:0]    now_ms,
   output tces_pkg::chan_state_type      nxt,
   output logic                          stop_event
);

   logic [tces_pkg::WORD_W-1:0]                     elapsed;
   logic                                            length_hit;
   logic                                            decay_on;
   logic [2*tces_pkg::GAIN_W-1:0]                   gain_prod;
   logic [tces_pkg::WORD_W+tces_pkg::SWEEP_W-1:0]   sweep_prod;
   logic [tces_pkg::WORD_W+tces_pkg::SWEEP_W-17:0]  sweep_shift;
   logic [tces_pkg::WORD_W-1:0]                     freq_swept;
   logic                                            end_hit;
   logic [tces_pkg::GAIN_W-1:0]                     play_gain;

   // note length, measured modulo 2^32
   assign elapsed    = now_ms - cur.start_time;
   assign length_hit = (cfg.length_ms != '0) && (elapsed >= cfg.length_ms);

   // gain decay, only for a factor strictly between zero and unity
   assign decay_on  = (cfg.decay_factor != '0) && (cfg.decay_factor < tces_pkg::UNITY_GAIN);
   assign gain_prod = cur.gain_now * cfg.decay_factor;

   // frequency sweep, saturate the shifted product to a full word
   assign sweep_prod  = cur.freq_now * cfg.sweep_factor;
   assign sweep_shift = sweep_prod[tces_pkg::WORD_W+tces_pkg::SWEEP_W-1:16];
   assign freq_swept  = (sweep_shift[tces_pkg::WORD_W+1:tces_pkg::WORD_W] != 2'b00)
                        ? {tces_pkg::WORD_W{1'b1}}
                        : sweep_shift[tces_pkg::WORD_W-1:0];

   // end stop in the direction of the sweep
   assign end_hit = (cfg.freq_end != '0) &&
                    (((cfg.sweep_factor > tces_pkg::UNITY_SWEEP) &&
                      (freq_swept >= cfg.freq_end)) ||
                     ((cfg.sweep_factor < tces_pkg::UNITY_SWEEP) &&
                      (freq_swept <= cfg.freq_end)));

   // clamp the start gain to unity on load
   assign play_gain = (cfg.start_gain > tces_pkg::UNITY_GAIN) ? tces_pkg::UNITY_GAIN
                                                              : cfg.start_gain;

   always_comb begin
      nxt = cur;
      case (tces_pkg::req_kind_type'(kind))
         tces_pkg::REQ_PLAY: begin
            nxt.gain_now   = play_gain;
            nxt.freq_now   = cfg.freq_start;
            nxt.start_time = now_ms;
            nxt.sounding   = 1'b1;
         end
         tces_pkg::REQ_STOP: begin
            nxt.sounding = 1'b0;
         end
         tces_pkg::REQ_TICK: begin
            if (length_hit) begin
               nxt.sounding = 1'b0;
            end
            if (decay_on) begin
               nxt.gain_now = gain_prod[tces_pkg::GAIN_W+15:16];
            end
            if (cfg.sweep_factor != '0) begin
               nxt.freq_now = freq_swept;
               if (end_hit) begin
                  nxt.sounding = 1'b0;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   assign stop_event = cur.sounding && !nxt.sounding;

endmodule : tces_step
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tone channel control block
// Drives request words and register writes, predicts every response word
// from a local model of note length, gain decay and frequency sweep, and
// compares each response field by field. Sender and receiver both idle at
// random, with one long receiver hold-off per few settings.
// ----------------------------------------------------------------------------
module tb;

   // request code with no meaning to the block
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   // register indexes past the end of the map
   localparam logic [tces_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [tces_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int RANDOM_SETTINGS  = 14;
   localparam int WORDS_PER_SETTING = 125;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int REPORT_CAP       = 40;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [tces_pkg::WORD_W-1:0] now;
   } note_word_type;

   typedef struct packed {
      logic [tces_pkg::GAIN_W-1:0] gain;
      logic [tces_pkg::WORD_W-1:0] freq;
      logic                        playing;
      logic                        stop_event;
   } note_result_type;

   logic                           clock;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic [1:0]                     req_type       = tces_pkg::REQ_TICK;
   logic [tces_pkg::WORD_W-1:0]    req_now_ms     = '0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic [tces_pkg::GAIN_W-1:0]    rsp_gain_out;
   logic [tces_pkg::WORD_W-1:0]    rsp_freq_out;
   logic                           rsp_playing;
   logic                           rsp_stop_event;
   logic                           csr_valid      = 1'b0;
   logic                           csr_ready;
   logic [tces_pkg::CSR_IDX_W-1:0] csr_index      = '0;
   logic [tces_pkg::WORD_W-1:0]    csr_data       = '0;

   // channel model: settings and note state
   tces_pkg::chan_cfg_type         tone_cfg;
   logic [tces_pkg::GAIN_W-1:0]    tone_gain;
   logic [tces_pkg::WORD_W-1:0]    tone_freq;
   logic [tces_pkg::WORD_W-1:0]    tone_start;
   logic                           tone_on;

   note_word_type        pending_words[$];
   note_result_type      expected_notes[$];
   note_word_type        next_word;
   note_result_type      want_note;
   note_result_type      got_note;

   int                   fail_count     = 0;
   int                   words_queued   = 0;
   int                   plays_queued   = 0;
   int                   settings_used  = 0;
   int                   stops_seen     = 0;
   int                   hold_requests  = 0;
   int                   holds_done     = 0;
   int                   hold_left      = 0;
   int                   stall_cycle    = 0;
   int                   burst_left     = 0;
   int                   gap_left       = 0;

   tone_channel_envelope_sweep_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_gain_out   (rsp_gain_out),
      .rsp_freq_out   (rsp_freq_out),
      .rsp_playing    (rsp_playing),
      .rsp_stop_event (rsp_stop_event),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

   // advance the channel model by one request word
   function automatic note_result_type predict_note(input logic [1:0] kind,
                                                    input logic [tces_pkg::WORD_W-1:0] now);
      note_result_type             r;
      logic                        was_on;
      logic [tces_pkg::WORD_W-1:0] elapsed;
      logic [33:0]                 gain_wide;
      logic [33:0]                 decay_wide;
      logic [49:0]                 freq_wide;
      logic [49:0]                 sweep_wide;
      logic [49:0]                 freq_prod;
      was_on = tone_on;
      case (kind)
         tces_pkg::REQ_PLAY: begin
            tone_gain  = (tone_cfg.start_gain > tces_pkg::UNITY_GAIN) ? tces_pkg::UNITY_GAIN
                                                                       : tone_cfg.start_gain;
            tone_freq  = tone_cfg.freq_start;
            tone_start = now;
            tone_on    = 1'b1;
         end
         tces_pkg::REQ_STOP: tone_on = 1'b0;
         tces_pkg::REQ_TICK: begin
            // note length, wrapping time difference
            elapsed = now - tone_start;
            if (tone_cfg.length_ms != '0 && elapsed >= tone_cfg.length_ms)
               tone_on = 1'b0;
            // gain decay, only for factors strictly below unity
            if (tone_cfg.decay_factor != '0 &&
                tone_cfg.decay_factor < tces_pkg::UNITY_GAIN) begin
               gain_wide  = 34'(tone_gain);
               decay_wide = 34'(tone_cfg.decay_factor);
               gain_wide  = gain_wide * decay_wide;
               tone_gain  = gain_wide[32:16];
            end
            // frequency sweep, saturating, with end stop in sweep direction
            if (tone_cfg.sweep_factor != '0) begin
               freq_wide  = 50'(tone_freq);
               sweep_wide = 50'(tone_cfg.sweep_factor);
               freq_prod  = freq_wide * sweep_wide;
               tone_freq  = (freq_prod[49:48] != 2'b00) ? '1 : freq_prod[47:16];
               if (tone_cfg.freq_end != '0) begin
                  if ((tone_cfg.sweep_factor > tces_pkg::UNITY_SWEEP &&
                       tone_freq >= tone_cfg.freq_end) ||
                      (tone_cfg.sweep_factor < tces_pkg::UNITY_SWEEP &&
                       tone_freq <= tone_cfg.freq_end))
                     tone_on = 1'b0;
               end
            end
         end
         default: ;
      endcase
      r.gain       = tone_gain;
      r.freq       = tone_freq;
      r.playing    = tone_on;
      r.stop_event = was_on && !tone_on;
      return r;
   endfunction

   // mirror a register write into the model; unmapped indexes drop out
   function automatic void store_setting(input logic [tces_pkg::CSR_IDX_W-1:0] idx,
                                         input logic [tces_pkg::WORD_W-1:0] data);
      case (idx)
         tces_pkg::CSR_START_GAIN:   tone_cfg.start_gain   = data[tces_pkg::GAIN_W-1:0];
         tces_pkg::CSR_DECAY_FACTOR: tone_cfg.decay_factor = data[tces_pkg::GAIN_W-1:0];
         tces_pkg::CSR_SWEEP_FACTOR: tone_cfg.sweep_factor = data[tces_pkg::SWEEP_W-1:0];
         tces_pkg::CSR_FREQ_START:   tone_cfg.freq_start   = data;
         tces_pkg::CSR_FREQ_END:     tone_cfg.freq_end     = data;
         tces_pkg::CSR_LENGTH_MS:    tone_cfg.length_ms    = data;
         default: ;
      endcase
   endfunction

   function automatic tces_pkg::chan_cfg_type make_settings(
         input logic [tces_pkg::GAIN_W-1:0]  gain,
         input logic [tces_pkg::GAIN_W-1:0]  decay,
         input logic [tces_pkg::SWEEP_W-1:0] sweep,
         input logic [tces_pkg::WORD_W-1:0]  f_start,
         input logic [tces_pkg::WORD_W-1:0]  f_end,
         input logic [tces_pkg::WORD_W-1:0]  len);
      tces_pkg::chan_cfg_type s;
      s.start_gain   = gain;
      s.decay_factor = decay;
      s.sweep_factor = sweep;
      s.freq_start   = f_start;
      s.freq_end     = f_end;
      s.length_ms    = len;
      return s;
   endfunction

   // random settings weighted towards extremes and slow envelopes
   function automatic tces_pkg::chan_cfg_type random_settings();
      tces_pkg::chan_cfg_type s;
      logic [31:0]            r;
      logic [31:0]            k;
      r = $urandom;
      case ($urandom_range(0, 4))
         0:       s.start_gain = '0;
         1:       s.start_gain = tces_pkg::UNITY_GAIN;
         2:       s.start_gain = '1;
         default: s.start_gain = r[16:0];
      endcase
      r = $urandom;
      case ($urandom_range(0, 7))
         0:       s.decay_factor = '0;
         1:       s.decay_factor = tces_pkg::UNITY_GAIN;
         2:       s.decay_factor = '1;
         3:       s.decay_factor = 17'h0FFFF;
         4:       s.decay_factor = 17'h00001;
         5, 6:    s.decay_factor = {5'b01111, r[11:0]};
         default: s.decay_factor = r[16:0];
      endcase
      r = $urandom;
      case ($urandom_range(0, 7))
         0:       s.sweep_factor = '0;
         1:       s.sweep_factor = tces_pkg::UNITY_SWEEP;
         2:       s.sweep_factor = '1;
         3, 4:    s.sweep_factor = {6'b001111, r[11:0]};
         5:       s.sweep_factor = {6'b010000, r[11:0]};
         default: s.sweep_factor = r[17:0];
      endcase
      r = $urandom;
      case ($urandom_range(0, 5))
         0:       s.freq_start = '0;
         1:       s.freq_start = '1;
         2, 3:    s.freq_start = {8'h00, r[23:0]};
         default: s.freq_start = r;
      endcase
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
         0:       s.freq_end = '0;
         1:       s.freq_end = s.freq_start + (s.freq_start >> k);
         2:       s.freq_end = s.freq_start - (s.freq_start >> (k + 1));
         3:       s.freq_end = s.freq_start;
         default: s.freq_end = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0:       s.length_ms = '0;
         1:       s.length_ms = 32'd1;
         2:       s.length_ms = '1;
         3, 4:    s.length_ms = $urandom_range(1, 300);
         default: s.length_ms = $urandom;
      endcase
      return s;
   endfunction

   // one register write; valid stays up for a following write
   task automatic write_csr(input logic [tces_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tces_pkg::WORD_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      store_setting(idx, data);
   endtask

   // write every register, optionally with noise in unused upper bits and writes to unmapped indexes
   task automatic apply_settings(input tces_pkg::chan_cfg_type s, input bit junk);
      logic [31:0] hi;
      hi = junk ? $urandom : 32'h0;
      @(posedge clock);
      write_csr(tces_pkg::CSR_START_GAIN,   {hi[31:tces_pkg::GAIN_W], s.start_gain});
      write_csr(tces_pkg::CSR_DECAY_FACTOR, {hi[31:tces_pkg::GAIN_W], s.decay_factor});
      write_csr(tces_pkg::CSR_SWEEP_FACTOR, {hi[31:tces_pkg::SWEEP_W], s.sweep_factor});
      write_csr(tces_pkg::CSR_FREQ_START,   s.freq_start);
      write_csr(tces_pkg::CSR_FREQ_END,     s.freq_end);
      write_csr(tces_pkg::CSR_LENGTH_MS,    s.length_ms);
      if (junk) begin
         write_csr(CSR_UNMAPPED_LO, $urandom);
         write_csr(CSR_UNMAPPED_HI, $urandom);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic offer(input logic [1:0] kind, input logic [tces_pkg::WORD_W-1:0] now);
      note_word_type w;
      w.kind = kind;
      w.now  = now;
      pending_words.push_back(w);
      words_queued++;
      if (kind == tces_pkg::REQ_PLAY) plays_queued++;
   endtask

   // mostly whole notes with random timing, the rest noise
   task automatic queue_phase(input int count);
      logic [tces_pkg::WORD_W-1:0] t;
      int                          n;
      int                          ticks;
      n = 0;
      t = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FFFF - $urandom_range(0, 2000)) : $urandom;
      while (n < count) begin
         if ($urandom_range(0, 4) != 0) begin
            offer(tces_pkg::REQ_PLAY, t);
            n++;
            ticks = $urandom_range(1, 24);
            repeat (ticks) begin
               t = t + (($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 16));
               offer(tces_pkg::REQ_TICK, t);
               n++;
            end
            if ($urandom_range(0, 2) == 0) begin
               t = t + $urandom_range(0, 8);
               offer(tces_pkg::REQ_STOP, t);
               n++;
            end
         end else begin
            offer(2'($urandom_range(0, 3)), ($urandom_range(0, 1) == 0) ? $urandom : t);
            n++;
         end
      end
   endtask

   // hold until every queued word is answered
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_notes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // request driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_type   <= tces_pkg::REQ_TICK;
         req_now_ms <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready)
            expected_notes.push_back(predict_note(req_type, req_now_ms));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               next_word = pending_words.pop_front();
               req_type   <= next_word.kind;
               req_now_ms <= next_word.now;
               req_valid  <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 20);
                  gap_left   = $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_note.gain       = rsp_gain_out;
            got_note.freq       = rsp_freq_out;
            got_note.playing    = rsp_playing;
            got_note.stop_event = rsp_stop_event;
            if (got_note.stop_event === 1'b1) stops_seen++;
            if (expected_notes.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_CAP)
                  $display("%0t: unexpected response word, expected none, actual %h",
                           $time, got_note);
            end else begin
               want_note = expected_notes.pop_front();
               check_field("gain_out",   32'(want_note.gain),       32'(got_note.gain));
               check_field("freq_out",   want_note.freq,            got_note.freq);
               check_field("playing",    32'(want_note.playing),    32'(got_note.playing));
               check_field("stop_event", 32'(want_note.stop_event), 32'(got_note.stop_event));
            end
         end
         stall_cycle++;
         if (holds_done != hold_requests && hold_left == 0) begin
            hold_left = LONG_HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case ((stall_cycle >> 6) % 5)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 0);
               2:       rsp_ready <= (stall_cycle % 4 != 3);
               3:       rsp_ready <= (stall_cycle % 3 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // stimulus sequence
   initial begin
      tone_cfg   = make_settings(tces_pkg::UNITY_GAIN, '0, '0, '0, '0, '0);
      tone_gain  = '0;
      tone_freq  = '0;
      tone_start = '0;
      tone_on    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset values: an idle tick, stops with nothing sounding, unknown code,
      // timestamp wrap, stop then repeated stop
      offer(tces_pkg::REQ_TICK, 32'h0000_0000);
      offer(tces_pkg::REQ_STOP, 32'hFFFF_FFFF);
      offer(REQ_UNKNOWN,        $urandom);
      offer(tces_pkg::REQ_PLAY, 32'hFFFF_FFF0);
      offer(tces_pkg::REQ_TICK, 32'h0000_0005);
      offer(REQ_UNKNOWN,        32'h0000_0006);
      offer(tces_pkg::REQ_STOP, 32'h0000_0007);
      offer(tces_pkg::REQ_STOP, 32'h0000_0008);
      wait_drained();

      // start gain above unity, decay above unity, saturating sweep, shortest note
      apply_settings(make_settings('1, '1, '1, '1, '0, 32'd1), 1'b1);
      offer(tces_pkg::REQ_PLAY, 32'd100);
      offer(tces_pkg::REQ_TICK, 32'd100);
      offer(tces_pkg::REQ_TICK, 32'd101);
      wait_drained();

      // smallest decay, downward sweep to an end stop, longest note
      apply_settings(make_settings(17'h0FFFF, 17'h00001, 18'h08000, 32'h0010_0000,
                                   32'h0004_0000, '1), 1'b0);
      offer(tces_pkg::REQ_PLAY, 32'd0);
      offer(tces_pkg::REQ_TICK, 32'd1);
      offer(tces_pkg::REQ_TICK, 32'd2);
      offer(tces_pkg::REQ_TICK, 32'd3);
      wait_drained();

      // largest decay below unity, unity sweep never reaches its end stop
      apply_settings(make_settings(tces_pkg::UNITY_GAIN, 17'h0FFFF, tces_pkg::UNITY_SWEEP,
                                   32'd1234, 32'd1234, '0), 1'b0);
      offer(tces_pkg::REQ_PLAY, 32'h8000_0000);
      offer(tces_pkg::REQ_TICK, 32'h8000_0001);
      offer(tces_pkg::REQ_TICK, 32'h8000_0002);
      wait_drained();

      // unity decay, upward sweep to an end stop, updates carry on after it
      apply_settings(make_settings(17'h08000, tces_pkg::UNITY_GAIN, 18'h20000, 32'h0000_1000,
                                   32'h0000_4000, '0), 1'b1);
      offer(tces_pkg::REQ_PLAY, 32'd50);
      offer(tces_pkg::REQ_TICK, 32'd60);
      offer(tces_pkg::REQ_TICK, 32'd70);
      offer(tces_pkg::REQ_TICK, 32'd80);
      wait_drained();

      // random settings, each with a batch of notes; some with a long hold-off
      for (int p = 0; p < RANDOM_SETTINGS; p++) begin
         apply_settings(random_settings(), 1'($urandom_range(0, 1)));
         if (p % 5 == 1) hold_requests++;
         queue_phase(WORDS_PER_SETTING);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (expected_notes.size() != 0) begin
         fail_count++;
         $display("%0t: %0d response words never arrived", $time, expected_notes.size());
      end
      $display("Ran %0d request words (%0d note starts) across %0d register settings.",
               words_queued, plays_queued, settings_used);
      $display("Saw %0d stop events; output held off %0d times; %0d failures.",
               stops_seen, holds_done, fail_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule : tb
`default_nettype wire

// File: files.f
hdl/tces_pkg.sv
hdl/tces_step.sv
hdl/tone_channel_envelope_sweep_unit.sv
verif/tb.sv
